// ----- src/pcm_stream_header_checker_top_macros.svh -----
// Assertion macros for the stream header checker.
`ifndef PCM_STREAM_HEADER_CHECKER_TOP_MACROS_SVH
`define PCM_STREAM_HEADER_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PCMHC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PCMHC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/pcmhc_pkg.sv -----
// Types, constants and decode functions for the stream header checker.
package pcmhc_pkg;

   localparam int unsigned HDR_LEN      = 32;
   localparam int unsigned POS_W        = $clog2(HDR_LEN);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(HDR_LEN - 1);
   localparam logic [15:0] HDR_VERSION  = 16'd1;
   localparam logic [15:0] HDR_LENGTH   = 16'(HDR_LEN);
   localparam logic [15:0] HDR_ENDIAN   = 16'd1;
   localparam logic [7:0]  MAX_CH_RESET = 8'd8;

   // early failure flag bits
   localparam int unsigned FL_MAGIC    = 0;
   localparam int unsigned FL_VERSION  = 1;
   localparam int unsigned FL_LENGTH   = 2;
   localparam int unsigned FL_ENDIAN   = 3;
   localparam int unsigned FL_RESERVED = 4;
   localparam int unsigned FL_W        = 5;

   typedef enum logic [3:0] {
      ERR_NONE     = 4'd0,
      ERR_MAGIC    = 4'd1,
      ERR_VERSION  = 4'd2,
      ERR_LENGTH   = 4'd3,
      ERR_ENDIAN   = 4'd4,
      ERR_RESERVED = 4'd5,
      ERR_FORMAT   = 4'd6,
      ERR_BITS     = 4'd7,
      ERR_RATE     = 4'd8,
      ERR_CHANNELS = 4'd9,
      ERR_FRAME    = 4'd10
   } err_code_type;

   typedef struct packed {
      logic [7:0] hdr_byte;
      logic       starts_header;
   } req_word_type;

   typedef struct packed {
      logic        header_ok;
      logic [3:0]  error_code;
      logic [17:0] sample_rate;
      logic [7:0]  channel_count;
      logic [2:0]  format_id;
      logic [2:0]  sample_bytes;
      logic [9:0]  frame_size;
   } rsp_word_type;

   // Gathered header, handed from the collector to the verdict stage.
   typedef struct packed {
      logic            fire;
      logic [FL_W-1:0] flags;
      logic [31:0]     rate;
      logic [15:0]     channels;
      logic [15:0]     format;
      logic [15:0]     bits;
      logic [31:0]     frame;
   } hdr_fields_type;

   function automatic logic [7:0] sync_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h4C; // L
         3'd1:    b = 8'h50; // P
         3'd2:    b = 8'h31; // 1
         3'd3:    b = 8'h30; // 0
         3'd4:    b = 8'h4E; // N
         3'd5:    b = 8'h41; // A
         3'd6:    b = 8'h55; // U
         default: b = 8'h31; // 1
      endcase
      return b;
   endfunction

   // logical bit depth per format id, 0 for unknown ids
   function automatic logic [5:0] fmt_bits(input logic [15:0] id);
      logic [5:0] r;
      case (id)
         16'd1:   r = 6'd16;
         16'd2:   r = 6'd24;
         16'd3:   r = 6'd24;
         16'd4:   r = 6'd32;
         default: r = 6'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] fmt_bytes(input logic [15:0] id);
      logic [2:0] r;
      case (id)
         16'd1:   r = 3'd2;
         16'd2:   r = 3'd4;
         16'd3:   r = 3'd3;
         16'd4:   r = 3'd4;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   function automatic logic rate_ok(input logic [31:0] r);
      return (r == 32'd44100) || (r == 32'd48000) || (r == 32'd88200) ||
             (r == 32'd96000) || (r == 32'd176400) || (r == 32'd192000);
   endfunction

endpackage

// ----- src/pcmhc_collect.sv -----
// Byte position tracking, field gathering and early checks.
module pcmhc_collect import pcmhc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  req_word_type   req_data,
   output logic           last_pending,
   output hdr_fields_type fields
);

   logic [POS_W-1:0] pos_ff, pos_in, pos;
   logic [31:0]      shift_ff, shift_in;
   logic [FL_W-1:0]  flags_ff, flags_in;
   logic [31:0]      rate_ff, rate_in;
   logic [15:0]      chan_ff, chan_in;
   logic [15:0]      fmt_ff, fmt_in;
   logic [15:0]      bits_ff, bits_in;
   logic [31:0]      frame_ff, frame_in;

   always_comb begin
      pos      = req_data.starts_header ? '0 : pos_ff;
      shift_in = {shift_ff[23:0], req_data.hdr_byte};
      flags_in = (pos == '0) ? '0 : flags_ff;
      rate_in  = rate_ff;
      chan_in  = chan_ff;
      fmt_in   = fmt_ff;
      bits_in  = bits_ff;
      frame_in = frame_ff;
      case (pos) inside
         [5'd0:5'd7]: begin
            if (req_data.hdr_byte != sync_byte(pos[2:0])) flags_in[FL_MAGIC] = 1'b1;
         end
         5'd9: begin
            if (shift_in[15:0] != HDR_VERSION) flags_in[FL_VERSION] = 1'b1;
         end
         5'd11: begin
            if (shift_in[15:0] != HDR_LENGTH) flags_in[FL_LENGTH] = 1'b1;
         end
         5'd15: rate_in  = shift_in;
         5'd17: chan_in  = shift_in[15:0];
         5'd19: fmt_in   = shift_in[15:0];
         5'd21: bits_in  = shift_in[15:0];
         5'd23: begin
            if (shift_in[15:0] != HDR_ENDIAN) flags_in[FL_ENDIAN] = 1'b1;
         end
         5'd27: frame_in = shift_in;
         5'd31: begin
            if (shift_in != 32'd0) flags_in[FL_RESERVED] = 1'b1;
         end
         default: ;
      endcase
      pos_in = pos + POS_W'(1); // wraps after the last byte
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         shift_ff <= '0;
         flags_ff <= '0;
         rate_ff  <= '0;
         chan_ff  <= '0;
         fmt_ff   <= '0;
         bits_ff  <= '0;
         frame_ff <= '0;
      end else if (accept) begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         flags_ff <= flags_in;
         rate_ff  <= rate_in;
         chan_ff  <= chan_in;
         fmt_ff   <= fmt_in;
         bits_ff  <= bits_in;
         frame_ff <= frame_in;
      end
   end

   // offered word would be the last header byte
   assign last_pending = (pos == POS_LAST);

   always_comb begin
      fields.fire     = accept && (pos == POS_LAST);
      fields.flags    = flags_in;
      fields.rate     = rate_ff;
      fields.channels = chan_ff;
      fields.format   = fmt_ff;
      fields.bits     = bits_ff;
      fields.frame    = frame_ff;
   end

endmodule

// ----- src/pcmhc_verdict.sv -----
// Final header checks and the result register.
module pcmhc_verdict import pcmhc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  hdr_fields_type fields,
   input  logic [7:0]     max_channels,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output rsp_word_type   rsp_data
);

   logic         valid_ff, valid_in;
   rsp_word_type data_ff, data_in;
   err_code_type code;
   logic [5:0]   logical;
   logic [2:0]   phys;
   logic [10:0]  expect_bytes;

   always_comb begin
      logical      = fmt_bits(fields.format);
      phys         = fmt_bytes(fields.format);
      expect_bytes = 11'(fields.channels[7:0] * phys);
      if (fields.flags[FL_MAGIC])            code = ERR_MAGIC;
      else if (fields.flags[FL_VERSION])     code = ERR_VERSION;
      else if (fields.flags[FL_LENGTH])      code = ERR_LENGTH;
      else if (fields.flags[FL_ENDIAN])      code = ERR_ENDIAN;
      else if (fields.flags[FL_RESERVED])    code = ERR_RESERVED;
      else if (logical == 6'd0)              code = ERR_FORMAT;
      else if (fields.bits != {10'd0, logical}) code = ERR_BITS;
      else if (!rate_ok(fields.rate))        code = ERR_RATE;
      else if ((fields.channels == 16'd0) ||
               (fields.channels > {8'd0, max_channels})) code = ERR_CHANNELS;
      else if (fields.frame != {21'd0, expect_bytes}) code = ERR_FRAME;
      else                                   code = ERR_NONE;

      data_in.header_ok  = (code == ERR_NONE);
      data_in.error_code = code;
      if (code == ERR_NONE) begin
         data_in.sample_rate   = fields.rate[17:0];
         data_in.channel_count = fields.channels[7:0];
         data_in.format_id     = fields.format[2:0];
         data_in.sample_bytes  = phys;
         data_in.frame_size    = expect_bytes[9:0];
      end else begin
         data_in.sample_rate   = '0;
         data_in.channel_count = '0;
         data_in.format_id     = '0;
         data_in.sample_bytes  = '0;
         data_in.frame_size    = '0;
      end
      // input side holds off a new verdict while one is stalled here
      valid_in = fields.fire || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fields.fire) begin
         data_ff <= data_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ----- src/pcm_stream_header_checker_top.sv -----
// Top level of the PCM stream header checker.
//
// Header bytes enter on the req_ channel, one word per byte in wire order;
// starts_header marks byte 0 and resets the byte position. After byte 31
// is taken, one verdict word leaves on the rsp_ channel: header_ok, the
// first failing check as error_code, and the decoded stream fields.
// A word is taken on a clock edge with valid high and stall low.
// The verdict register is valid in the cycle after byte 31 is accepted.
// Bytes are taken one per cycle unless req_stall holds them off; field
// gathering and the final checks each fit in one register stage.
// While a verdict waits under rsp_stall, header bytes keep flowing; only
// the byte that would complete the next header is held off by req_stall.
// csr_wr_en writes csr_wr_data into max_channels (reset value 8); write it
// only while the block is idle.
// Synchronous reset clears the byte position, gathered fields, the early
// failure flags and the result valid, and loads max_channels with 8.
module pcm_stream_header_checker_top import pcmhc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

`include "pcm_stream_header_checker_top_macros.svh"

   logic [7:0]     max_channels_ff;
   logic           accept;
   logic           last_pending;
   hdr_fields_type fields;
   logic           reject_seen, reject_clean;
   logic           ok_seen, frame_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_channels_ff <= MAX_CH_RESET;
      end else if (csr_wr_en) begin
         max_channels_ff <= csr_wr_data;
      end
   end

   assign req_stall = rsp_valid && rsp_stall && last_pending;
   assign accept    = req_valid && !req_stall;

   pcmhc_collect u_collect (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .last_pending (last_pending),
      .fields       (fields)
   );

   pcmhc_verdict u_verdict (
      .clock        (clock),
      .reset        (reset),
      .fields       (fields),
      .max_channels (max_channels_ff),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data)
   );

   assign reject_seen  = rsp_valid && !rsp_data.header_ok;
   assign reject_clean = (rsp_data.sample_rate == '0) && (rsp_data.channel_count == '0) &&
                         (rsp_data.frame_size == '0);
   assign ok_seen      = rsp_valid && rsp_data.header_ok;
   assign frame_match  = (rsp_data.frame_size ==
                          10'(rsp_data.channel_count * rsp_data.sample_bytes));

   `PCMHC_ASSERT_NEXT(a_verdict_follows, clock, reset, fields.fire, rsp_valid, "no verdict")
   `PCMHC_ASSERT_NOW(a_reject_zeroes, clock, reset, reject_seen, reject_clean, "reject fields set")
   `PCMHC_ASSERT_NOW(a_frame_math, clock, reset, ok_seen, frame_match, "frame size mismatch")

endmodule

// ----- tb/tb_pcm_stream_header_checker_top.sv -----
// Self-checking testbench for the PCM stream header checker.
`timescale 1ns / 100ps

module tb_pcm_stream_header_checker_top;
   import pcmhc_pkg::*;

   // sync word, byte 0 in the top byte
   localparam logic [63:0] SYNC_WORD = 64'h4C50_3130_4E41_5531;

   // one whole header as it appears on the wire, byte 0 first
   typedef struct packed {
      logic [63:0] magic;
      logic [15:0] version;
      logic [15:0] hdr_len;
      logic [31:0] rate;
      logic [15:0] channels;
      logic [15:0] format;
      logic [15:0] bits;
      logic [15:0] endian;
      logic [31:0] frame;
      logic [31:0] reserved;
   } hdr_image_type;

   typedef struct {
      logic [7:0]    max_ch;
      bit            lead;
      int            nbytes;
      bit            typed;
      err_code_type  code;
      logic [2:0]    sbytes;
      hdr_image_type hdr;
   } hdr_case_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [7:0]   csr_wr_data = '0;

   // header checker state as predicted
   logic [4:0]  trk_pos = '0;
   logic [31:0] trk_shift = '0;
   logic [4:0]  trk_flags = '0;
   logic [31:0] trk_rate = '0;
   logic [15:0] trk_channels = '0;
   logic [15:0] trk_format = '0;
   logic [15:0] trk_bits = '0;
   logic [31:0] trk_frame = '0;
   logic [7:0]  max_ch_cfg = MAX_CH_RESET;

   rsp_word_type verdicts_due [$];
   rsp_word_type verdict_head;
   int unsigned  mismatches = 0;
   int unsigned  bytes_sent = 0;
   int unsigned  verdicts_queued = 0;
   int unsigned  idle_pct = 22;
   int unsigned  stall_pct = 22;

   hdr_case_type header_cases [25] = '{
      '{8'd8, 1'b1, 32, 1'b1, ERR_NONE, 3'd2,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_MAGIC, 3'd0,
        '{64'h0, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_MAGIC, 3'd0,
        '{64'h4C50_3130_4E41_5530, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd1, 16'd16,
          16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_VERSION, 3'd0,
        '{SYNC_WORD, 16'd0, 16'd32, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_VERSION, 3'd0,
        '{SYNC_WORD, 16'hFFFF, 16'hFFFF, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4,
          32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_LENGTH, 3'd0,
        '{SYNC_WORD, 16'd1, 16'hFFFF, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_ENDIAN, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd0, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_RESERVED, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4,
          32'hFFFF_FFFF}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_FORMAT, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd0, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_FORMAT, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd2, 16'hFFFF, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_BITS, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd2, 16'd32, 16'd1, 32'd8, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_RATE, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd0, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_RATE, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'hFFFF_FFFF, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_CHANNELS, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd0, 16'd1, 16'd16, 16'd1, 32'd0, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_CHANNELS, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd9, 16'd1, 16'd16, 16'd1, 32'd18, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_FRAME, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd1, 32'h1000_0004,
          32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_MAGIC, 3'd0,
        '{64'h0, 16'd0, 16'd0, 32'd0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0, 32'hFFFF_FFFF}},
      // cut short, the next header restarts with the start flag
      '{8'd8, 1'b1, 20, 1'b0, ERR_NONE, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'd2, 16'd1, 16'd16, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b1, 32, 1'b1, ERR_NONE, 3'd3,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd192000, 16'd8, 16'd3, 16'd24, 16'd1, 32'd24, 32'd0}},
      // no start flag: position wraps after byte 31
      '{8'd8, 1'b0, 32, 1'b1, ERR_NONE, 3'd4,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd44100, 16'd1, 16'd4, 16'd32, 16'd1, 32'd4, 32'd0}},
      '{8'd8, 1'b0, 32, 1'b1, ERR_NONE, 3'd4,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd88200, 16'd3, 16'd2, 16'd24, 16'd1, 32'd12, 32'd0}},
      '{8'd255, 1'b1, 32, 1'b1, ERR_NONE, 3'd4,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd176400, 16'd255, 16'd4, 16'd32, 16'd1, 32'd1020,
          32'd0}},
      '{8'd255, 1'b1, 32, 1'b1, ERR_CHANNELS, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd48000, 16'h0100, 16'd1, 16'd16, 16'd1, 32'd0, 32'd0}},
      // zero limit rejects every channel count
      '{8'd0, 1'b1, 32, 1'b1, ERR_CHANNELS, 3'd0,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd96000, 16'd1, 16'd1, 16'd16, 16'd1, 32'd2, 32'd0}},
      '{8'd1, 1'b1, 32, 1'b1, ERR_NONE, 3'd2,
        '{SYNC_WORD, 16'd1, 16'd32, 32'd96000, 16'd1, 16'd1, 16'd16, 16'd1, 32'd2, 32'd0}}
   };

   pcm_stream_header_checker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Advances the predicted state by one header byte; returns 1 with the
   // verdict when the byte completes a header.
   function automatic bit predict_verdict(input req_word_type w, output rsp_word_type v);
      logic [4:0]   p;
      logic [5:0]   logical;
      logic [2:0]   phys;
      logic [31:0]  frame_want;
      bit           rate_good;
      err_code_type code;
      if (w.starts_header) trk_pos = '0;
      p = trk_pos;
      if (p == 5'd0) trk_flags = '0;
      trk_shift = {trk_shift[23:0], w.hdr_byte};
      if (p < 5'd8) begin
         if (w.hdr_byte != SYNC_WORD[8*(7-p) +: 8]) trk_flags[FL_MAGIC] = 1'b1;
      end else begin
         case (p)
            5'd9:  if (trk_shift[15:0] != HDR_VERSION) trk_flags[FL_VERSION] = 1'b1;
            5'd11: if (trk_shift[15:0] != HDR_LENGTH) trk_flags[FL_LENGTH] = 1'b1;
            5'd15: trk_rate = trk_shift;
            5'd17: trk_channels = trk_shift[15:0];
            5'd19: trk_format = trk_shift[15:0];
            5'd21: trk_bits = trk_shift[15:0];
            5'd23: if (trk_shift[15:0] != HDR_ENDIAN) trk_flags[FL_ENDIAN] = 1'b1;
            5'd27: trk_frame = trk_shift;
            5'd31: if (trk_shift != 32'd0) trk_flags[FL_RESERVED] = 1'b1;
            default: ;
         endcase
      end
      trk_pos = p + 5'd1;
      v = '0;
      if (p != 5'd31) return 1'b0;

      case (trk_format)
         16'd1: begin logical = 6'd16; phys = 3'd2; end
         16'd2: begin logical = 6'd24; phys = 3'd4; end
         16'd3: begin logical = 6'd24; phys = 3'd3; end
         16'd4: begin logical = 6'd32; phys = 3'd4; end
         default: begin logical = 6'd0; phys = 3'd0; end
      endcase
      case (trk_rate)
         32'd44100, 32'd48000, 32'd88200, 32'd96000, 32'd176400, 32'd192000:
            rate_good = 1'b1;
         default: rate_good = 1'b0;
      endcase
      frame_want = 32'(trk_channels[7:0]) * 32'(phys);

      if (trk_flags[FL_MAGIC]) code = ERR_MAGIC;
      else if (trk_flags[FL_VERSION]) code = ERR_VERSION;
      else if (trk_flags[FL_LENGTH]) code = ERR_LENGTH;
      else if (trk_flags[FL_ENDIAN]) code = ERR_ENDIAN;
      else if (trk_flags[FL_RESERVED]) code = ERR_RESERVED;
      else if (logical == 6'd0) code = ERR_FORMAT;
      else if (trk_bits != 16'(logical)) code = ERR_BITS;
      else if (!rate_good) code = ERR_RATE;
      else if (trk_channels == 16'd0 || trk_channels > 16'(max_ch_cfg)) code = ERR_CHANNELS;
      else if (trk_frame != frame_want) code = ERR_FRAME;
      else code = ERR_NONE;

      v.error_code = code;
      if (code == ERR_NONE) begin
         v.header_ok     = 1'b1;
         v.sample_rate   = trk_rate[17:0];
         v.channel_count = trk_channels[7:0];
         v.format_id     = trk_format[2:0];
         v.sample_bytes  = phys;
         v.frame_size    = frame_want[9:0];
      end
      return 1'b1;
   endfunction

   // Mostly well-formed header, with up to three fields broken at random.
   function automatic hdr_image_type random_header(input logic [7:0] max_ch);
      hdr_image_type h;
      logic [2:0]    phys;
      int            nmut;
      h.magic    = SYNC_WORD;
      h.version  = HDR_VERSION;
      h.hdr_len  = HDR_LENGTH;
      h.endian   = HDR_ENDIAN;
      h.reserved = '0;
      h.format   = 16'($urandom_range(4, 1));
      case (h.format)
         16'd1: begin h.bits = 16'd16; phys = 3'd2; end
         16'd2: begin h.bits = 16'd24; phys = 3'd4; end
         16'd3: begin h.bits = 16'd24; phys = 3'd3; end
         default: begin h.bits = 16'd32; phys = 3'd4; end
      endcase
      case ($urandom_range(5))
         0: h.rate = 32'd44100;
         1: h.rate = 32'd48000;
         2: h.rate = 32'd88200;
         3: h.rate = 32'd96000;
         4: h.rate = 32'd176400;
         default: h.rate = 32'd192000;
      endcase
      h.channels = (max_ch == 8'd0) ? 16'($urandom_range(255, 1))
                                    : 16'($urandom_range(int'(max_ch), 1));
      h.frame = 32'(h.channels) * 32'(phys);
      nmut = ($urandom_range(99) < 45) ? 0 : $urandom_range(3, 1);
      repeat (nmut) begin
         case ($urandom_range(10, 1))
            1: h.magic[$urandom_range(63)] ^= 1'b1;
            2: h.version = 16'($urandom);
            3: h.hdr_len = 16'($urandom);
            4: h.endian = 16'($urandom);
            5: h.reserved = $urandom;
            6: h.format = ($urandom_range(1) != 0) ? 16'd0 : 16'($urandom);
            7: h.bits = 16'($urandom_range(40));
            8: h.rate ^= 32'd1 << $urandom_range(31);
            9: h.channels = ($urandom_range(1) != 0) ? 16'd0
                            : 16'($urandom_range(65535, int'(max_ch) + 1));
            default: h.frame ^= 32'd1 << $urandom_range(31);
         endcase
      end
      return h;
   endfunction

   task automatic note_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      if (mismatches < 100)
         $display("%0t: mismatch %s: got %0d, want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Drives one word; returns at the clock edge that takes it.
   task automatic push_byte(input req_word_type w, input bit typed, input rsp_word_type want);
      rsp_word_type v;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      if (predict_verdict(w, v)) begin
         verdicts_due.push_back(typed ? want : v);
         verdicts_queued++;
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_header(input hdr_image_type h, input int nbytes, input bit lead,
                              input bit typed, input rsp_word_type want);
      logic [255:0] flat;
      req_word_type w;
      flat = h;
      for (int i = 0; i < nbytes; i++) begin
         w.hdr_byte      = flat[255 - 8*i -: 8];
         w.starts_header = lead && (i == 0);
         push_byte(w, typed, want);
      end
   endtask

   // Only written with the block idle: no verdict pending, pipeline flushed.
   task automatic set_max_channels(input logic [7:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en  <= 1'b0;
      max_ch_cfg = value;
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdicts_due.size() == 0) begin
            note_mismatch("verdict with none pending, error_code", rsp_data.error_code, 0);
         end else begin
            verdict_head = verdicts_due.pop_front();
            if (rsp_data.header_ok !== verdict_head.header_ok)
               note_mismatch("header_ok", rsp_data.header_ok, verdict_head.header_ok);
            if (rsp_data.error_code !== verdict_head.error_code)
               note_mismatch("error_code", rsp_data.error_code, verdict_head.error_code);
            if (rsp_data.sample_rate !== verdict_head.sample_rate)
               note_mismatch("sample_rate", rsp_data.sample_rate, verdict_head.sample_rate);
            if (rsp_data.channel_count !== verdict_head.channel_count)
               note_mismatch("channel_count", rsp_data.channel_count,
                             verdict_head.channel_count);
            if (rsp_data.format_id !== verdict_head.format_id)
               note_mismatch("format_id", rsp_data.format_id, verdict_head.format_id);
            if (rsp_data.sample_bytes !== verdict_head.sample_bytes)
               note_mismatch("sample_bytes", rsp_data.sample_bytes, verdict_head.sample_bytes);
            if (rsp_data.frame_size !== verdict_head.frame_size)
               note_mismatch("frame_size", rsp_data.frame_size, verdict_head.frame_size);
         end
      end
   end

   initial begin
      rsp_word_type want;
      req_word_type w;
      logic [7:0]   mc;
      int unsigned  kind;
      int unsigned  byte_goal;
      int unsigned  verdict_goal;
      bit           lead;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (header_cases[k]) begin
         if (header_cases[k].max_ch != max_ch_cfg) set_max_channels(header_cases[k].max_ch);
         want = '0;
         want.error_code = header_cases[k].code;
         if (header_cases[k].code == ERR_NONE) begin
            want.header_ok     = 1'b1;
            want.sample_rate   = header_cases[k].hdr.rate[17:0];
            want.channel_count = header_cases[k].hdr.channels[7:0];
            want.format_id     = header_cases[k].hdr.format[2:0];
            want.sample_bytes  = header_cases[k].sbytes;
            want.frame_size    = header_cases[k].hdr.frame[9:0];
         end
         send_header(header_cases[k].hdr, header_cases[k].nbytes, header_cases[k].lead,
                     header_cases[k].typed, want);
      end

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: mc = 8'd255;
            1: mc = 8'd1;
            2: mc = 8'd0;
            3: mc = 8'($urandom_range(254, 2));
            default: mc = MAX_CH_RESET;
         endcase
         set_max_channels(mc);
         // one phase runs back to back on both sides
         idle_pct  = (ph == 3) ? 0 : 22;
         stall_pct = idle_pct;
         byte_goal    = bytes_sent + ((ph == 3) ? 64 : 8);
         verdict_goal = verdicts_queued + ((ph == 3) ? 2 : 1);
         while (bytes_sent < byte_goal || verdicts_queued < verdict_goal) begin
            kind = $urandom_range(99);
            // a start flag is needed unless the last header was completed
            lead = (trk_pos != 5'd0) || ($urandom_range(3) != 0);
            if (kind < 80) begin
               send_header(random_header(max_ch_cfg), 32, lead, 1'b0, '0);
            end else if (kind < 90) begin
               send_header(random_header(max_ch_cfg), $urandom_range(31, 1), lead, 1'b0, '0);
            end else begin
               repeat ($urandom_range(40, 1)) begin
                  w.hdr_byte      = 8'($urandom);
                  w.starts_header = ($urandom_range(7) == 0);
                  push_byte(w, 1'b0, '0);
               end
            end
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (verdicts_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb_pcm_stream_header_checker_top OK");
      else
         $display("tb_pcm_stream_header_checker_top NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb_pcm_stream_header_checker_top NOT OK");
      $finish;
   end

endmodule
